>>> rtl/uartc_pkg.sv
// Shared types and constants for the console UART ring buffer engine.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package uartc_pkg;

  typedef enum logic [2:0] {
    REQ_TX_PUT    = 3'd0,
    REQ_RX_LINE   = 3'd1,
    REQ_TX_PULL   = 3'd2,
    REQ_RX_GET    = 3'd3,
    REQ_RX_FLUSH  = 3'd4,
    REQ_SNAP      = 3'd5,
    REQ_SNAP_READ = 3'd6,
    REQ_NOP       = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_DENIED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT_LF,
    S_TX_RD,
    S_RX_RD,
    S_SCAN,
    S_SCAN_CHK
  } state_t;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_XON  = 8'h11;
  localparam logic [7:0] CH_XOFF = 8'h13;

endpackage

`default_nettype wire

>>> rtl/uart_console_ring_buffers.sv
// Console UART buffer engine: transmit ring, receive ring and history reader.
// Depends on uartc_pkg and two instances of uartc_ram.
`default_nettype none

// A request is taken when start is high and busy is low; its one result is
// shown for a single cycle with done high and cannot be held off. Tx put of an
// ordinary byte, line bytes, rx flush, refused snapshots and the unused code
// finish at once, so such requests may follow one another every cycle. A
// newline put that stores its carriage return goes on to S_PUT_LF for its line
// feed, and a tx pull or rx get that returns a byte goes on to S_TX_RD or
// S_RX_RD for the registered read of the ring memory. Snapshot and snapshot
// read alternate S_SCAN and S_SCAN_CHK, a memory read and a check per zero
// history byte skipped, until a non-zero byte or the write pointer ends the
// walk. After reset the transmit memory is cleared one entry a cycle, with busy
// high until the last is written; configuration writes are taken throughout.
module uart_console_ring_buffers #(
  parameter int TX_DEPTH = 512,
  parameter int RX_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] req_type,
  input  wire logic [7:0] data_in,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  output logic            done,
  output logic      [1:0] status,
  output logic      [7:0] data_out,
  output logic            tx_enabled,
  output logic            rx_pending
);

  localparam int TXW = $clog2(TX_DEPTH);
  localparam int RXW = $clog2(RX_DEPTH);

  function automatic logic [TXW-1:0] tx_adv(input logic [TXW-1:0] i);
    return (i == TXW'(TX_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [RXW-1:0] rx_adv(input logic [RXW-1:0] i);
    return (i == RXW'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  uartc_pkg::state_t state, state_next;

  logic [TXW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [TXW-1:0] snap_head, snap_head_next, snap_tail, snap_tail_next;
  logic [TXW-1:0] clr_addr;
  logic [RXW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic           suspended, suspended_next;
  logic           snap_rd, snap_rd_next;
  logic           console_locked;

  logic           tx_we;
  logic [TXW-1:0] tx_waddr, tx_raddr;
  logic [7:0]     tx_wdata, tx_rdata;
  logic           rx_we;
  logic [7:0]     rx_rdata;

  logic                fin;
  uartc_pkg::status_t  fin_status;
  logic [7:0]          fin_dout;

  uartc_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  uartc_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head),
    .wdata (data_in),
    .raddr (rx_tail),
    .rdata (rx_rdata)
  );

  assign busy = (state != uartc_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    tx_head_next   = tx_head;
    tx_tail_next   = tx_tail;
    rx_head_next   = rx_head;
    rx_tail_next   = rx_tail;
    snap_head_next = snap_head;
    snap_tail_next = snap_tail;
    suspended_next = suspended;
    snap_rd_next   = snap_rd;
    tx_we          = 1'b0;
    tx_waddr       = tx_head;
    tx_wdata       = data_in;
    tx_raddr       = tx_tail;
    rx_we          = 1'b0;
    fin            = 1'b0;
    fin_status     = uartc_pkg::ST_OK;
    fin_dout       = 8'h00;

    unique case (state)
      uartc_pkg::S_CLEAR: begin
        tx_we    = 1'b1;
        tx_waddr = clr_addr;
        tx_wdata = 8'h00;
        if (clr_addr == TXW'(TX_DEPTH - 1)) begin
          state_next = uartc_pkg::S_IDLE;
        end
      end

      uartc_pkg::S_IDLE: begin
        if (start) begin
          unique case (uartc_pkg::req_t'(req_type))
            uartc_pkg::REQ_TX_PUT: begin
              if (tx_adv(tx_head) == tx_tail) begin
                fin        = 1'b1;
                fin_status = uartc_pkg::ST_FULL;
              end else begin
                tx_we        = 1'b1;
                tx_wdata     = (data_in == uartc_pkg::CH_LF) ? uartc_pkg::CH_CR : data_in;
                tx_head_next = tx_adv(tx_head);
                if (data_in == uartc_pkg::CH_LF) begin
                  state_next = uartc_pkg::S_PUT_LF;
                end else begin
                  fin = 1'b1;
                end
              end
            end
            uartc_pkg::REQ_RX_LINE: begin
              fin = 1'b1;
              if (data_in == uartc_pkg::CH_XOFF) begin
                suspended_next = 1'b1;
              end else if (data_in == uartc_pkg::CH_XON) begin
                suspended_next = 1'b0;
              end else if (rx_adv(rx_head) == rx_tail) begin
                fin_status = uartc_pkg::ST_FULL;
              end else begin
                rx_we        = 1'b1;
                rx_head_next = rx_adv(rx_head);
              end
            end
            uartc_pkg::REQ_TX_PULL: begin
              if (suspended || tx_head == tx_tail) begin
                fin        = 1'b1;
                fin_status = uartc_pkg::ST_EMPTY;
              end else begin
                state_next = uartc_pkg::S_TX_RD;
              end
            end
            uartc_pkg::REQ_RX_GET: begin
              if (rx_head == rx_tail) begin
                fin        = 1'b1;
                fin_status = uartc_pkg::ST_EMPTY;
              end else begin
                state_next = uartc_pkg::S_RX_RD;
              end
            end
            uartc_pkg::REQ_RX_FLUSH: begin
              fin          = 1'b1;
              rx_tail_next = rx_head;
            end
            uartc_pkg::REQ_SNAP: begin
              if (console_locked) begin
                fin        = 1'b1;
                fin_status = uartc_pkg::ST_DENIED;
              end else begin
                snap_head_next = tx_head;
                snap_tail_next = tx_adv(tx_head);
                snap_rd_next   = 1'b0;
                state_next     = uartc_pkg::S_SCAN;
              end
            end
            uartc_pkg::REQ_SNAP_READ: begin
              if (console_locked) begin
                fin        = 1'b1;
                fin_status = uartc_pkg::ST_DENIED;
              end else begin
                snap_rd_next = 1'b1;
                state_next   = uartc_pkg::S_SCAN;
              end
            end
            uartc_pkg::REQ_NOP: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Second half of a newline: LF goes in only if there is still room.
      uartc_pkg::S_PUT_LF: begin
        fin        = 1'b1;
        state_next = uartc_pkg::S_IDLE;
        if (tx_adv(tx_head) == tx_tail) begin
          fin_status = uartc_pkg::ST_FULL;
        end else begin
          tx_we        = 1'b1;
          tx_wdata     = uartc_pkg::CH_LF;
          tx_head_next = tx_adv(tx_head);
        end
      end

      uartc_pkg::S_TX_RD: begin
        fin          = 1'b1;
        fin_dout     = tx_rdata;
        tx_tail_next = tx_adv(tx_tail);
        state_next   = uartc_pkg::S_IDLE;
      end

      uartc_pkg::S_RX_RD: begin
        fin          = 1'b1;
        fin_dout     = rx_rdata;
        rx_tail_next = rx_adv(rx_tail);
        state_next   = uartc_pkg::S_IDLE;
      end

      uartc_pkg::S_SCAN: begin
        tx_raddr = snap_tail;
        if (snap_tail == snap_head) begin
          fin        = 1'b1;
          fin_status = snap_rd ? uartc_pkg::ST_EMPTY : uartc_pkg::ST_OK;
          state_next = uartc_pkg::S_IDLE;
        end else begin
          state_next = uartc_pkg::S_SCAN_CHK;
        end
      end

      // A zero byte is skipped; the first non-zero one ends the walk.
      uartc_pkg::S_SCAN_CHK: begin
        if (tx_rdata == 8'h00) begin
          snap_tail_next = tx_adv(snap_tail);
          state_next     = uartc_pkg::S_SCAN;
        end else begin
          fin        = 1'b1;
          state_next = uartc_pkg::S_IDLE;
          if (snap_rd) begin
            fin_dout       = tx_rdata;
            snap_tail_next = tx_adv(snap_tail);
          end
        end
      end

      default: begin
        state_next = uartc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= uartc_pkg::S_CLEAR;
      clr_addr       <= '0;
      tx_head        <= '0;
      tx_tail        <= '0;
      rx_head        <= '0;
      rx_tail        <= '0;
      snap_head      <= '0;
      snap_tail      <= '0;
      suspended      <= 1'b0;
      snap_rd        <= 1'b0;
      console_locked <= 1'b0;
      done           <= 1'b0;
      tx_enabled     <= 1'b0;
      rx_pending     <= 1'b0;
    end else begin
      state     <= state_next;
      tx_head   <= tx_head_next;
      tx_tail   <= tx_tail_next;
      rx_head   <= rx_head_next;
      rx_tail   <= rx_tail_next;
      snap_head <= snap_head_next;
      snap_tail <= snap_tail_next;
      suspended <= suspended_next;
      snap_rd   <= snap_rd_next;
      done      <= fin;
      if (state == uartc_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        console_locked <= cfg_data;
      end
      if (fin) begin
        tx_enabled <= !suspended_next && (tx_head_next != tx_tail_next);
        rx_pending <= (rx_head_next != rx_tail_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status   <= fin_status;
      data_out <= fin_dout;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uartc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module uartc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/uartc_checker.sv
// Port-level checks for the console UART buffer engine, bound to its top level.
// Depends on uartc_pkg and on the port list of uart_console_ring_buffers.
`default_nettype none

module uartc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] req_type,
  input wire logic [7:0] data_in,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [7:0] data_out,
  input wire logic       tx_enabled,
  input wire logic       rx_pending
);

  logic accepted;
  assign accepted = start && !busy;

  // The transmit memory is cleared after reset, so no request is taken.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("engine not busy clearing after reset");

  a_dout_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && status != uartc_pkg::ST_OK |-> data_out == 8'h00)
    else $error("data_out non-zero on a failed beat");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    accepted && req_type == uartc_pkg::REQ_RX_FLUSH |=> done && !rx_pending)
    else $error("rx flush left bytes pending");

  a_xoff_stops_tx: assert property (@(posedge clk) disable iff (rst)
    accepted && req_type == uartc_pkg::REQ_RX_LINE && data_in == uartc_pkg::CH_XOFF
    |=> done && status == uartc_pkg::ST_OK && !tx_enabled)
    else $error("XOFF did not suspend the transmitter");

endmodule

bind uart_console_ring_buffers uartc_checker u_uartc_checker (.*);

`default_nettype wire

>>> sim/uart_console_ring_buffers_test.sv
// Self-checking testbench for the console UART ring buffer engine.
// Depends on uartc_pkg and uart_console_ring_buffers; it runs a directed table
// followed by random requests, checked by a built-in predictor or typed table rows.
`default_nettype none

module uart_console_ring_buffers_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TXD = 512;
  localparam int RXD = 128;

  typedef struct {
    uartc_pkg::status_t status;
    logic [7:0]         data;
    logic               tx_en;
    logic               rx_pend;
  } reply_t;

  typedef struct {
    bit              is_cfg;
    uartc_pkg::req_t req;
    logic [7:0]      data;
    bit              typed;
    reply_t          want;
  } plan_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] req_type = uartc_pkg::REQ_NOP;
  logic [7:0] data_in = 8'h00;
  logic       cfg_we = 1'b0;
  logic       cfg_data = 1'b0;
  logic       busy;
  logic       done;
  logic [1:0] status;
  logic [7:0] data_out;
  logic       tx_enabled;
  logic       rx_pending;

  // Predictor state: both rings, flow control and the history reader.
  logic [7:0] tx_mem [TXD];
  logic [8:0] tx_wr = '0;
  logic [8:0] tx_rd = '0;
  logic [7:0] rx_mem [RXD];
  logic [6:0] rx_wr = '0;
  logic [6:0] rx_rd = '0;
  bit         paused = 1'b0;
  logic [8:0] hist_end = '0;
  logic [8:0] hist_pos = '0;
  bit         locked = 1'b0;

  reply_t     replies_due[$];
  bit         taken;
  bit         typed_on = 1'b0;
  reply_t     typed_reply;
  int         idle_pct = 13;
  int         items = 0;
  int         errors = 0;

  uart_console_ring_buffers DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .data_in    (data_in),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .data_out   (data_out),
    .tx_enabled (tx_enabled),
    .rx_pending (rx_pending)
  );

  function automatic int tx_room();
    logic [8:0] r;
    r = tx_rd - tx_wr - 9'd1;
    return int'(r);
  endfunction

  function automatic int rx_room();
    logic [6:0] r;
    r = rx_rd - rx_wr - 7'd1;
    return int'(r);
  endfunction

  function automatic int rx_count();
    logic [6:0] c;
    c = rx_wr - rx_rd;
    return int'(c);
  endfunction

  function automatic bit tx_push(logic [7:0] b);
    logic [8:0] nxt;
    nxt = tx_wr + 9'd1;
    if (nxt == tx_rd) return 1'b0;
    tx_mem[tx_wr] = b;
    tx_wr = nxt;
    return 1'b1;
  endfunction

  // The history reader passes over zero bytes, stopping at the write pointer.
  function automatic void skip_zero_history();
    while (hist_pos != hist_end && tx_mem[hist_pos] == 8'h00) hist_pos = hist_pos + 9'd1;
  endfunction

  function automatic reply_t buffer_step(uartc_pkg::req_t r, logic [7:0] d);
    reply_t     y;
    logic [6:0] nxt;
    y.status = uartc_pkg::ST_OK;
    y.data = 8'h00;
    case (r)
      uartc_pkg::REQ_TX_PUT: begin
        if (d == uartc_pkg::CH_LF) begin
          // A carriage return goes first and stays even when the line feed is refused.
          if (!tx_push(uartc_pkg::CH_CR)) y.status = uartc_pkg::ST_FULL;
          else if (!tx_push(uartc_pkg::CH_LF)) y.status = uartc_pkg::ST_FULL;
        end else if (!tx_push(d)) begin
          y.status = uartc_pkg::ST_FULL;
        end
      end
      uartc_pkg::REQ_RX_LINE: begin
        if (d == uartc_pkg::CH_XOFF) begin
          paused = 1'b1;
        end else if (d == uartc_pkg::CH_XON) begin
          paused = 1'b0;
        end else begin
          nxt = rx_wr + 7'd1;
          if (nxt == rx_rd) begin
            y.status = uartc_pkg::ST_FULL;
          end else begin
            rx_mem[rx_wr] = d;
            rx_wr = nxt;
          end
        end
      end
      uartc_pkg::REQ_TX_PULL: begin
        if (paused || tx_wr == tx_rd) begin
          y.status = uartc_pkg::ST_EMPTY;
        end else begin
          y.data = tx_mem[tx_rd];
          tx_rd = tx_rd + 9'd1;
        end
      end
      uartc_pkg::REQ_RX_GET: begin
        if (rx_wr == rx_rd) begin
          y.status = uartc_pkg::ST_EMPTY;
        end else begin
          y.data = rx_mem[rx_rd];
          rx_rd = rx_rd + 7'd1;
        end
      end
      uartc_pkg::REQ_RX_FLUSH: rx_rd = rx_wr;
      uartc_pkg::REQ_SNAP: begin
        if (locked) begin
          y.status = uartc_pkg::ST_DENIED;
        end else begin
          hist_end = tx_wr;
          hist_pos = tx_wr + 9'd1;
          skip_zero_history();
        end
      end
      uartc_pkg::REQ_SNAP_READ: begin
        if (locked) begin
          y.status = uartc_pkg::ST_DENIED;
        end else begin
          skip_zero_history();
          if (hist_pos == hist_end) begin
            y.status = uartc_pkg::ST_EMPTY;
          end else begin
            y.data = tx_mem[hist_pos];
            hist_pos = hist_pos + 9'd1;
          end
        end
      end
      default: ;
    endcase
    y.tx_en = !paused && tx_wr != tx_rd;
    y.rx_pend = rx_wr != rx_rd;
    return y;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_reply();
    reply_t y;
    if (replies_due.size() == 0) begin
      report("unexpected result beat", 1, 0);
      return;
    end
    y = replies_due.pop_front();
    if (status !== y.status) report("status", status, y.status);
    if (data_out !== y.data) report("data_out", data_out, y.data);
    if (tx_enabled !== y.tx_en) report("tx_enabled", tx_enabled, y.tx_en);
    if (rx_pending !== y.rx_pend) report("rx_pending", rx_pending, y.rx_pend);
  endtask

  // One clock: a request beat taken at this edge is predicted before any result
  // beat is checked, so the order of the two never depends on the scheduler.
  task automatic tick();
    reply_t y;
    @(posedge clk);
    taken = 1'b0;
    if (start === 1'b1 && busy === 1'b0) begin
      y = buffer_step(uartc_pkg::req_t'(req_type), data_in);
      if (typed_on) y = typed_reply;
      replies_due.push_back(y);
      taken = 1'b1;
    end
    if (done === 1'b1) check_reply();
  endtask

  task automatic send(uartc_pkg::req_t r, logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      tick();
    end
    start    <= 1'b1;
    req_type <= r;
    data_in  <= d;
    tick();
    while (!taken) tick();
    items++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (replies_due.size() != 0) tick();
    repeat (4) tick();
  endtask

  task automatic set_lock(bit v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    tick();
    cfg_we   <= 1'b0;
    locked = v;
  endtask

  function automatic plan_row_t ask(uartc_pkg::req_t r, logic [7:0] d);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.req = r;
    p.data = d;
    p.typed = 1'b0;
    p.want.status = uartc_pkg::ST_OK;
    p.want.data = 8'h00;
    p.want.tx_en = 1'b0;
    p.want.rx_pend = 1'b0;
    return p;
  endfunction

  function automatic plan_row_t ask_expect(uartc_pkg::req_t r, logic [7:0] d,
                                           uartc_pkg::status_t s, logic [7:0] q,
                                           logic te, logic rp);
    plan_row_t p;
    p = ask(r, d);
    p.typed = 1'b1;
    p.want.status = s;
    p.want.data = q;
    p.want.tx_en = te;
    p.want.rx_pend = rp;
    return p;
  endfunction

  function automatic plan_row_t lock_row(bit v);
    plan_row_t p;
    p = ask(uartc_pkg::REQ_NOP, {7'd0, v});
    p.is_cfg = 1'b1;
    return p;
  endfunction

  function automatic logic [7:0] put_byte();
    // Aim a newline at the last free slot so that only its carriage return fits.
    if (tx_room() == 1 && $urandom_range(1) == 1) return uartc_pkg::CH_LF;
    if ($urandom_range(99) < 12) return uartc_pkg::CH_LF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0: return uartc_pkg::CH_LF;
      1: return uartc_pkg::CH_XON;
      2: return uartc_pkg::CH_XOFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    int        budget;
    int        pick;
    int        n;
    int        guard;

    for (int i = 0; i < TXD; i++) tx_mem[i] = 8'h00;
    for (int i = 0; i < RXD; i++) rx_mem[i] = 8'h00;

    plan.push_back(lock_row(1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_TX_PULL, 8'h00, uartc_pkg::ST_EMPTY,
                              8'h00, 1'b0, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_RX_GET, 8'hFF, uartc_pkg::ST_EMPTY,
                              8'h00, 1'b0, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_SNAP_READ, 8'h00, uartc_pkg::ST_EMPTY,
                              8'h00, 1'b0, 1'b0));
    // A snapshot straight after reset walks the whole zero history.
    plan.push_back(ask_expect(uartc_pkg::REQ_SNAP, 8'h00, uartc_pkg::ST_OK,
                              8'h00, 1'b0, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_TX_PUT, 8'hFF, uartc_pkg::ST_OK,
                              8'h00, 1'b1, 1'b0));
    plan.push_back(ask(uartc_pkg::REQ_TX_PUT, 8'h00));
    plan.push_back(ask(uartc_pkg::REQ_TX_PUT, uartc_pkg::CH_LF));
    plan.push_back(ask_expect(uartc_pkg::REQ_RX_LINE, uartc_pkg::CH_XOFF, uartc_pkg::ST_OK,
                              8'h00, 1'b0, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_TX_PULL, 8'h00, uartc_pkg::ST_EMPTY,
                              8'h00, 1'b0, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_RX_LINE, uartc_pkg::CH_XON, uartc_pkg::ST_OK,
                              8'h00, 1'b1, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_TX_PULL, 8'h00, uartc_pkg::ST_OK,
                              8'hFF, 1'b1, 1'b0));
    plan.push_back(ask(uartc_pkg::REQ_RX_LINE, 8'h00));
    plan.push_back(ask(uartc_pkg::REQ_RX_LINE, 8'hFF));
    plan.push_back(ask(uartc_pkg::REQ_RX_GET, 8'h00));
    plan.push_back(ask(uartc_pkg::REQ_RX_FLUSH, 8'h00));
    plan.push_back(ask(uartc_pkg::REQ_SNAP, 8'h00));
    repeat (4) plan.push_back(ask(uartc_pkg::REQ_SNAP_READ, 8'h00));
    plan.push_back(ask(uartc_pkg::REQ_NOP, 8'h55));
    plan.push_back(lock_row(1'b1));
    plan.push_back(ask_expect(uartc_pkg::REQ_SNAP, 8'h00, uartc_pkg::ST_DENIED,
                              8'h00, 1'b1, 1'b0));
    plan.push_back(ask_expect(uartc_pkg::REQ_SNAP_READ, 8'hAA, uartc_pkg::ST_DENIED,
                              8'h00, 1'b1, 1'b0));

    repeat (8) tick();
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        set_lock(plan[i].data[0]);
      end else begin
        typed_on = plan[i].typed;
        typed_reply = plan[i].want;
        send(plan[i].req, plan[i].data);
        typed_on = 1'b0;
      end
    end

    // Random sequences: each segment pairs a sender idling rate with a lock setting.
    // Long ring bursts can overrun each segment's budget.
    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 13 : (seg < 4) ? 54 : 0;
      settle();
      set_lock(bit'(seg % 2));
      budget = items + 170;
      while (items < budget) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          // Fill the transmit ring, then knock on it while full.
          guard = 0;
          while (tx_room() > 0 && guard < 600) begin
            send(uartc_pkg::REQ_TX_PUT, put_byte());
            guard++;
          end
          repeat (3) send(uartc_pkg::REQ_TX_PUT, put_byte());
        end else if (pick < 28) begin
          guard = 0;
          while (tx_wr != tx_rd && guard < 700) begin
            n = $urandom_range(19);
            if (n == 0) send(uartc_pkg::REQ_RX_LINE, uartc_pkg::CH_XOFF);
            else if (paused && n < 10) send(uartc_pkg::REQ_RX_LINE, uartc_pkg::CH_XON);
            else send(uartc_pkg::REQ_TX_PULL, 8'($urandom_range(255)));
            guard++;
          end
          send(uartc_pkg::REQ_TX_PULL, 8'($urandom_range(255)));
        end else if (pick < 42) begin
          guard = 0;
          while (rx_room() > 0 && guard < 200) begin
            send(uartc_pkg::REQ_RX_LINE, 8'($urandom_range(255)));
            guard++;
          end
          repeat (3) send(uartc_pkg::REQ_RX_LINE, 8'($urandom_range(255)));
        end else if (pick < 56) begin
          n = rx_count() + 2;
          repeat (n)
            send(($urandom_range(29) == 0) ? uartc_pkg::REQ_RX_FLUSH : uartc_pkg::REQ_RX_GET,
                 8'($urandom_range(255)));
        end else if (pick < 72) begin
          send(uartc_pkg::REQ_SNAP, 8'($urandom_range(255)));
          repeat ($urandom_range(1, 40))
            send(uartc_pkg::REQ_SNAP_READ, 8'($urandom_range(255)));
        end else begin
          repeat (30) send(uartc_pkg::req_t'($urandom_range(7)), noise_byte());
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
